@@ hdl/jdcal_pkg.sv @@
// Shared constants, types and tables for the Julian date to calendar converter.
package jdcal_pkg;

  // Register stages from an accepted beat to the result register.
  localparam int STAGES = 9;
  // Stage at which the time of day is complete.
  localparam int CLK_DONE = 4;

  localparam logic [23:0] GREG_START = 24'd2299161;
  localparam logic [25:0] B_BIAS     = 26'd7468865;

  // Exact reciprocals: floor(n / D) == (n * ceil(2^k / D)) >> k for the operand ranges used.
  localparam int          B_SHIFT = 43;
  localparam logic [25:0] B_MUL   = 26'(((64'd1 << B_SHIFT) + 64'd146096) / 64'd146097);
  localparam int          D_SHIFT = 41;
  localparam logic [28:0] D_MUL   = 29'(((64'd1 << D_SHIFT) + 64'd7304) / 64'd7305);
  localparam int          F_SHIFT = 42;
  localparam logic [37:0] F_MUL   =
    38'(64'd10000 * (((64'd1 << F_SHIFT) + 64'd306000) / 64'd306001));

  typedef struct packed {
    logic [STAGES-1:0] en;  // bit i loads stage i+1
  } jdcal_adv_t;

  // floor(30.6001 * f): day count before the month coded by f.
  function automatic logic [8:0] month_start(input logic [3:0] f);
    logic [8:0] v;
    unique case (f)
      4'd0:  v = 9'd0;
      4'd1:  v = 9'd30;
      4'd2:  v = 9'd61;
      4'd3:  v = 9'd91;
      4'd4:  v = 9'd122;
      4'd5:  v = 9'd153;
      4'd6:  v = 9'd183;
      4'd7:  v = 9'd214;
      4'd8:  v = 9'd244;
      4'd9:  v = 9'd275;
      4'd10: v = 9'd306;
      4'd11: v = 9'd336;
      4'd12: v = 9'd367;
      4'd13: v = 9'd397;
      4'd14: v = 9'd428;
      4'd15: v = 9'd459;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/julian_day_to_calendar.sv @@
// Top level of the Julian date to calendar date and time converter.
//
//   channel   handshake              payload
//   input     jd_valid / jd_ready    julian_date
//   output    cal_valid / cal_ready  year, month_of_year, day_of_month, hour_of_day,
//                                    minute_of_hour, second_fixed, weekday
//
// Nine register stages; one beat may enter each cycle while jd_ready is high. The
// depth is set by the chain of three reciprocal multipliers in the date path. A full
// stage holds when its successor is full and stalled, so a stall at the output fills
// bubbles before jd_ready falls.
// Reset clears the valid bits.
module julian_day_to_calendar (
  input  logic               clk,
  input  logic               rst,
  input  logic               jd_valid,
  output logic               jd_ready,
  input  logic [46:0]        julian_date,
  output logic               cal_valid,
  input  logic               cal_ready,
  output logic signed [15:0] year,
  output logic [3:0]         month_of_year,
  output logic [4:0]         day_of_month,
  output logic [4:0]         hour_of_day,
  output logic [5:0]         minute_of_hour,
  output logic [21:0]        second_fixed,
  output logic [2:0]         weekday
);
  import jdcal_pkg::*;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] v_next;
  jdcal_adv_t        adv;
  logic [15:0]       year_bits;

  always_comb begin
    adv.en[STAGES-1] = !v[STAGES-1] || cal_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv.en[i] = !v[i] || adv.en[i+1];
    end
    v_next = {v[STAGES-2:0], jd_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (adv.en[i]) begin
          v[i] <= v_next[i];
        end
      end
    end
  end

  assign jd_ready  = adv.en[0];
  assign cal_valid = v[STAGES-1];
  assign year      = signed'(year_bits);

  jdcal_date u_date (
    .clk           (clk),
    .adv           (adv),
    .jd_day        (julian_date[46:23]),
    .year          (year_bits),
    .month_of_year (month_of_year),
    .day_of_month  (day_of_month),
    .weekday       (weekday)
  );

  jdcal_clock u_clock (
    .clk            (clk),
    .adv            (adv),
    .jd_frac        (julian_date[23:0]),
    .hour_of_day    (hour_of_day),
    .minute_of_hour (minute_of_hour),
    .second_fixed   (second_fixed)
  );

`ifndef NO_ASSERTIONS
  // The input side may only refuse a beat when every stage is occupied.
  a_full_only: assert property (@(posedge clk) disable iff (rst) !jd_ready |-> (&v))
    else $error("input stalled while the pipeline has a free stage");

  a_enter: assert property (@(posedge clk) disable iff (rst) (jd_valid && jd_ready) |=> v[0])
    else $error("accepted beat did not enter the first stage");

  a_legal: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> (month_of_year >= 4'd1 && month_of_year <= 4'd12 &&
                   day_of_month >= 5'd1 && hour_of_day < 5'd24 &&
                   minute_of_hour < 6'd60 && weekday < 3'd7))
    else $error("result beat holds an impossible date or time");
`endif

endmodule

@@ hdl/jdcal_date.sv @@
// Date pipeline: day number to year, month, day of month and weekday.
module jdcal_date (
  input  logic                   clk,
  input  jdcal_pkg::jdcal_adv_t  adv,
  input  logic [23:0]            jd_day,
  output logic [15:0]            year,
  output logic [3:0]             month_of_year,
  output logic [4:0]             day_of_month,
  output logic [2:0]             weekday
);
  import jdcal_pkg::*;

  logic [23:0] a1, a2, a3;
  logic [24:0] n1_2;
  logic        greg2, greg3;
  logic [5:0]  wsum2;
  logic [7:0]  b3;
  logic [23:0] c4, c5, c6;
  logic [27:0] n2_5;
  logic [14:0] d6, d7, d8;
  logic [8:0]  g7, g8;
  logic [3:0]  f8;
  logic [2:0]  wd_q [3:STAGES];

  logic [23:0] w;
  logic [5:0]  wsum;
  logic [3:0]  fold;
  logic [2:0]  wd;
  logic [25:0] n1_wide;
  logic [50:0] prod1;
  logic [56:0] prod2;
  logic [25:0] e_wide;
  logic [23:0] g_wide;
  logic [46:0] prod3;
  logic [3:0]  mon;

  always_comb begin
    // Eight is one more than seven, so the octal digit sum keeps the residue.
    w = a1 + 24'd1;
    wsum = '0;
    for (int i = 0; i < 8; i++) begin
      wsum = wsum + 6'(w[3*i +: 3]);
    end
    fold = 4'(wsum2[5:3]) + 4'(wsum2[2:0]);
    wd = (fold >= 4'd14) ? 3'(fold - 4'd14) :
         (fold >= 4'd7)  ? 3'(fold - 4'd7)  : fold[2:0];
    n1_wide = {a1, 2'b00} - B_BIAS;
    prod1 = 51'(n1_2) * 51'(B_MUL);
    prod2 = 57'(n2_5) * 57'(D_MUL);
    e_wide = 26'(d6) * 26'd1461;
    g_wide = c6 - e_wide[25:2];
    prod3 = 47'(g7) * 47'(F_MUL);
    mon = (f8 < 4'd14) ? f8 - 4'd1 : f8 - 4'd13;
  end

  always_ff @(posedge clk) begin
    if (adv.en[0]) begin
      a1 <= 24'(jd_day[23:1]) + 24'(jd_day[0]);
    end
    if (adv.en[1]) begin
      a2    <= a1;
      n1_2  <= n1_wide[24:0];
      greg2 <= (a1 >= GREG_START);
      wsum2 <= wsum;
    end
    if (adv.en[2]) begin
      a3       <= a2;
      greg3    <= greg2;
      b3       <= prod1[B_SHIFT +: 8];
      wd_q[3]  <= wd;
    end
    if (adv.en[3]) begin
      // Gregorian correction drops three leap days in every four centuries.
      c4 <= greg3 ? a3 + 24'(b3) - 24'(b3[7:2]) + 24'd1525 : a3 + 24'd1524;
    end
    if (adv.en[4]) begin
      c5   <= c4;
      n2_5 <= {c4, 4'b0000} + 28'({c4, 2'b00}) - 28'd2442;
    end
    if (adv.en[5]) begin
      c6 <= c5;
      d6 <= prod2[D_SHIFT +: 15];
    end
    if (adv.en[6]) begin
      d7 <= d6;
      g7 <= g_wide[8:0];
    end
    if (adv.en[7]) begin
      d8 <= d7;
      g8 <= g7;
      f8 <= prod3[F_SHIFT +: 4];
    end
    if (adv.en[8]) begin
      day_of_month  <= 5'(g8 - month_start(f8));
      month_of_year <= mon;
      year          <= 16'(d8) - 16'd4715 - 16'(mon > 4'd2);
    end
    for (int i = 4; i <= STAGES; i++) begin
      if (adv.en[i-1]) begin
        wd_q[i] <= wd_q[i-1];
      end
    end
  end

  assign weekday = wd_q[STAGES];

endmodule

@@ hdl/jdcal_clock.sv @@
// Time of day pipeline: fraction of a day to hours, minutes and fixed-point seconds.
module jdcal_clock (
  input  logic                   clk,
  input  jdcal_pkg::jdcal_adv_t  adv,
  input  logic [23:0]            jd_frac,
  output logic [4:0]             hour_of_day,
  output logic [5:0]             minute_of_hour,
  output logic [21:0]            second_fixed
);
  import jdcal_pkg::*;

  logic [23:0] fr1;
  logic [23:0] xf2;
  logic [23:0] rf3;
  logic [4:0]  hr_q  [2:STAGES];
  logic [5:0]  mn_q  [3:STAGES];
  logic [21:0] sec_q [CLK_DONE:STAGES];

  logic [28:0] x;
  logic [29:0] r;
  logic [29:0] s;

  always_comb begin
    x = {fr1, 5'b00000} - 29'({fr1, 3'b000});
    r = {xf2, 6'b000000} - 30'({xf2, 2'b00});
    s = {rf3, 6'b000000} - 30'({rf3, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (adv.en[0]) begin
      // Adding half a day flips the top fraction bit and carries into the day.
      fr1 <= {~jd_frac[23], jd_frac[22:0]};
    end
    if (adv.en[1]) begin
      hr_q[2] <= x[28:24];
      xf2     <= x[23:0];
    end
    if (adv.en[2]) begin
      hr_q[3] <= hr_q[2];
      mn_q[3] <= r[29:24];
      rf3     <= r[23:0];
    end
    if (adv.en[3]) begin
      hr_q[4]  <= hr_q[3];
      mn_q[4]  <= mn_q[3];
      sec_q[4] <= s[29:8];
    end
    for (int i = CLK_DONE + 1; i <= STAGES; i++) begin
      if (adv.en[i-1]) begin
        hr_q[i]  <= hr_q[i-1];
        mn_q[i]  <= mn_q[i-1];
        sec_q[i] <= sec_q[i-1];
      end
    end
  end

  assign hour_of_day    = hr_q[STAGES];
  assign minute_of_hour = mn_q[STAGES];
  assign second_fixed   = sec_q[STAGES];

endmodule
